@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ src/tpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch mapper package
// Shared constants, register indexes and status codes of the touch mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

	// Default widths of the fixed-point touch fraction and of pixel dimensions.
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIM_BITS_DEF  = 14;

	// Rotation register width and the four supported angles.
	localparam int ROT_BITS = 9;
	localparam logic [ROT_BITS-1:0] ROT_0   = ROT_BITS'(0);
	localparam logic [ROT_BITS-1:0] ROT_90  = ROT_BITS'(90);
	localparam logic [ROT_BITS-1:0] ROT_180 = ROT_BITS'(180);
	localparam logic [ROT_BITS-1:0] ROT_270 = ROT_BITS'(270);

	// Configuration register index width.
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DRAWABLE_WIDTH  = 3'd0,
		REG_DRAWABLE_HEIGHT = 3'd1,
		REG_INSET_LEFT      = 3'd2,
		REG_INSET_TOP       = 3'd3,
		REG_INSET_RIGHT     = 3'd4,
		REG_INSET_BOTTOM    = 3'd5,
		REG_ROTATION_DEG    = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_BAD_INSET = 2'd2,
		ST_BAD_ROT  = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ src/tpm_channels.sv @@
// ----------------------------------------------------------------------------
// Touch mapper channels
// Valid/ready interfaces for touch items, pixel items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpm_touch_if #(
	parameter int IN_W = tpm_pkg::FRAC_BITS_DEF + 2
);
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] touch_x;
	logic signed [IN_W-1:0] touch_y;

	modport source (output valid, output touch_x, output touch_y, input ready);
	modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

interface tpm_pixel_if #(
	parameter int DIM_W = tpm_pkg::DIM_BITS_DEF
);
	logic             valid;
	logic             ready;
	logic [DIM_W-1:0] pixel_x;
	logic [DIM_W-1:0] pixel_y;
	logic [1:0]       status;

	modport source (output valid, output pixel_x, output pixel_y, output status, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input status, output ready);
endinterface

interface tpm_cfg_if #(
	parameter int DATA_W = tpm_pkg::DIM_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic [tpm_pkg::CFG_IDX_BITS-1:0] index;
	logic [DATA_W-1:0]                data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/touch_point_to_pixel_mapper_core.sv @@
// ----------------------------------------------------------------------------
// Touch point to pixel mapper
// Clamps, rotates, scales and offsets a normalized touch point into a pixel
// of the usable area of a drawable surface.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                          Handshake
//   -------   ---------  -------------------------------  ------------
//   touch     in         touch_x, touch_y (signed Q2.F)    valid/ready
//   pixel     out        pixel_x, pixel_y, status          valid/ready
//   cfg       in         index, data                       valid/ready
//
// Each touch item yields one pixel item, offered from the result register after
// the input register; a new item can enter in every cycle unless the pixel side
// stalls. The two multiplies (one per axis) sit between the input and result
// registers and set the cycle time. Reset clears both valid bits and loads a
// 1x1 drawable with no insets and no rotation. A pixel stall fills the input
// register before touch ready drops; register writes are always taken.
`default_nettype none

module touch_point_to_pixel_mapper_core
	import tpm_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DIM_BITS  = DIM_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	tpm_touch_if.sink    touch,
	tpm_pixel_if.source  pixel,
	tpm_cfg_if.sink      cfg
);

	localparam int IN_W   = FRAC_BITS + 2;
	localparam int NRM_W  = FRAC_BITS + 1;         // 0 .. 1.0 inclusive
	localparam int PROD_W = NRM_W + DIM_BITS;
	localparam int POS_W  = DIM_BITS + 2;
	localparam logic [NRM_W-1:0] ONE_FX = NRM_W'(1) << FRAC_BITS;

	// Clamp a signed Q2.F value to the range 0 .. 1.0.
	function automatic logic [NRM_W-1:0] unit_clamp(input logic signed [IN_W-1:0] v);
		logic [NRM_W-1:0] mag;
		mag = v[NRM_W-1:0];
		if (v[IN_W-1]) begin
			return '0;
		end else if (mag > ONE_FX) begin
			return ONE_FX;
		end else begin
			return mag;
		end
	endfunction

	// Near inset plus truncated scaled coordinate, clamped to the last pixel.
	// The sum can never fall below the near inset, so only the upper clamp
	// is needed.
	function automatic logic [DIM_BITS-1:0] place(
		input logic [NRM_W-1:0]    r,
		input logic [DIM_BITS-1:0] near,
		input logic [DIM_BITS-1:0] usable,
		input logic [DIM_BITS-1:0] last
	);
		logic [PROD_W-1:0] prod;
		logic [POS_W-1:0]  pos;
		prod = PROD_W'(r) * PROD_W'(usable);
		pos  = POS_W'(prod[PROD_W-1:FRAC_BITS]) + POS_W'(near);
		if (pos > POS_W'(last)) begin
			return last;
		end else begin
			return pos[DIM_BITS-1:0];
		end
	endfunction

	// Configuration registers.
	logic [DIM_BITS-1:0] drawable_width_q;
	logic [DIM_BITS-1:0] drawable_height_q;
	logic [DIM_BITS-1:0] inset_left_q;
	logic [DIM_BITS-1:0] inset_top_q;
	logic [DIM_BITS-1:0] inset_right_q;
	logic [DIM_BITS-1:0] inset_bottom_q;
	logic [ROT_BITS-1:0] rotation_deg_q;

	// Input stage and result stage.
	logic                   valid_s1;
	logic signed [IN_W-1:0] touch_x_s1;
	logic signed [IN_W-1:0] touch_y_s1;
	logic                   valid_s2;
	logic [DIM_BITS-1:0]    pixel_x_s2;
	logic [DIM_BITS-1:0]    pixel_y_s2;
	status_t                status_s2;

	logic advance_s2;
	logic advance_s1;

	// Mapping logic between the two stages.
	logic [NRM_W-1:0]    nx, ny, rx, ry;
	logic                rot_ok;
	logic [DIM_BITS:0]   inset_sum_x, inset_sum_y;
	logic [DIM_BITS-1:0] usable_w, usable_h, last_x, last_y;
	logic [DIM_BITS-1:0] map_x, map_y;
	status_t             map_status;

	// Register writes are accepted at any time; an unknown index is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drawable_width_q  <= DIM_BITS'(1);
			drawable_height_q <= DIM_BITS'(1);
			inset_left_q      <= '0;
			inset_top_q       <= '0;
			inset_right_q     <= '0;
			inset_bottom_q    <= '0;
			rotation_deg_q    <= ROT_0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_DRAWABLE_WIDTH:  drawable_width_q  <= cfg.data[DIM_BITS-1:0];
				REG_DRAWABLE_HEIGHT: drawable_height_q <= cfg.data[DIM_BITS-1:0];
				REG_INSET_LEFT:      inset_left_q      <= cfg.data[DIM_BITS-1:0];
				REG_INSET_TOP:       inset_top_q       <= cfg.data[DIM_BITS-1:0];
				REG_INSET_RIGHT:     inset_right_q     <= cfg.data[DIM_BITS-1:0];
				REG_INSET_BOTTOM:    inset_bottom_q    <= cfg.data[DIM_BITS-1:0];
				REG_ROTATION_DEG:    rotation_deg_q    <= cfg.data[ROT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The result register empties when the sink takes it; the input register
	// moves forward whenever the result register is free to load.
	assign advance_s2  = !valid_s2 || pixel.ready;
	assign advance_s1  = advance_s2;
	assign touch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (touch.ready) begin
				valid_s1 <= touch.valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (touch.valid && touch.ready) begin
			touch_x_s1 <= touch.touch_x;
			touch_y_s1 <= touch.touch_y;
		end
		if (advance_s2 && valid_s1) begin
			pixel_x_s2 <= map_x;
			pixel_y_s2 <= map_y;
			status_s2  <= map_status;
		end
	end

	always_comb begin
		nx = unit_clamp(touch_x_s1);
		ny = unit_clamp(touch_y_s1);

		// Rotation swaps axes and mirrors them with 1.0 - n where needed.
		rot_ok = 1'b1;
		case (rotation_deg_q)
			ROT_0: begin
				rx = nx;
				ry = ny;
			end
			ROT_90: begin
				rx = ONE_FX - ny;
				ry = nx;
			end
			ROT_180: begin
				rx = ONE_FX - nx;
				ry = ONE_FX - ny;
			end
			ROT_270: begin
				rx = ny;
				ry = ONE_FX - nx;
			end
			default: begin
				rx     = '0;
				ry     = '0;
				rot_ok = 1'b0;
			end
		endcase

		inset_sum_x = {1'b0, inset_left_q} + {1'b0, inset_right_q};
		inset_sum_y = {1'b0, inset_top_q} + {1'b0, inset_bottom_q};
		usable_w    = drawable_width_q - inset_left_q - inset_right_q;
		usable_h    = drawable_height_q - inset_top_q - inset_bottom_q;
		last_x      = drawable_width_q - inset_right_q - DIM_BITS'(1);
		last_y      = drawable_height_q - inset_bottom_q - DIM_BITS'(1);

		map_x = '0;
		map_y = '0;
		if (drawable_width_q == '0 || drawable_height_q == '0) begin
			map_status = ST_BAD_SIZE;
		end else if (inset_sum_x >= {1'b0, drawable_width_q} ||
				inset_sum_y >= {1'b0, drawable_height_q}) begin
			map_status = ST_BAD_INSET;
		end else if (!rot_ok) begin
			map_status = ST_BAD_ROT;
		end else begin
			map_status = ST_OK;
			map_x      = place(rx, inset_left_q, usable_w, last_x);
			map_y      = place(ry, inset_top_q, usable_h, last_y);
		end
	end

	assign pixel.valid   = valid_s2;
	assign pixel.pixel_x = pixel_x_s2;
	assign pixel.pixel_y = pixel_y_s2;
	assign pixel.status  = status_s2;

endmodule

`default_nettype wire

@@ src/tpm_checker.sv @@
// ----------------------------------------------------------------------------
// Touch mapper checker
// Port-level assertions on the touch mapper, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpm_checker
	import tpm_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input wire                clk,
	input wire                arst_n,
	input wire                touch_ready,
	input wire                pixel_valid,
	input wire                pixel_ready,
	input wire [DIM_BITS-1:0] pixel_x,
	input wire [DIM_BITS-1:0] pixel_y,
	input wire [1:0]          status
);

	logic out_wait;
	logic out_err;

	assign out_wait = pixel_valid && !pixel_ready;
	assign out_err  = pixel_valid && (status != ST_OK);

	// An error result carries no pixel coordinates.
	`ASSERT_IMPLIES(a_err_zero, clk, arst_n, out_err, pixel_x == '0 && pixel_y == '0)

	// Touch side only stalls when a finished result is held up downstream.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !touch_ready, out_wait)

	// A result that is not taken stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, pixel_valid)

	// A result that is not taken keeps its contents.
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_wait, $stable({pixel_x, pixel_y, status}))

endmodule

bind touch_point_to_pixel_mapper_core tpm_checker #(
	.DIM_BITS(DIM_BITS)
) u_tpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.touch_ready (touch.ready),
	.pixel_valid (pixel.valid),
	.pixel_ready (pixel.ready),
	.pixel_x     (pixel.pixel_x),
	.pixel_y     (pixel.pixel_y),
	.status      (pixel.status)
);

`default_nettype wire

@@ tb/touch_point_to_pixel_mapper_core_tb.sv @@
// ----------------------------------------------------------------------------
// Touch mapper testbench
// Drives touch items and register writes into the touch point to pixel mapper
// and checks every pixel item against a scoreboard computed in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_point_to_pixel_mapper_core_tb;
	import tpm_pkg::*;

	// Widths follow the package defaults. The DUT is built with the same values.
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int DIM  = DIM_BITS_DEF;
	localparam int IN_W = FRAC + 2;

	// One point zero in the touch format, and the extremes of a touch field.
	localparam longint UNIT      = longint'(1) << FRAC;
	localparam int     TOUCH_MIN = -(1 << (IN_W - 1));
	localparam int     TOUCH_MAX = (1 << (IN_W - 1)) - 1;
	localparam int     DIM_MAX   = (1 << DIM) - 1;

	// Index past the end of the register map; writes to it must do nothing.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	// The pipeline is two stages deep: an input register and a result register.
	localparam int PIPE_DEPTH = 2;

	// The longest legal quiet stretch is a sender gap plus a receiver stall plus
	// the pipe. The watchdog allows far more than that.
	localparam int QUIET_LIMIT = 1000;
	localparam int MAX_WAIT    = 17;
	localparam int RAND_PHASES = 30;

	typedef struct {
		logic [DIM-1:0] px;
		logic [DIM-1:0] py;
		status_t        st;
	} pixel_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tpm_touch_if #(.IN_W(IN_W)) touch_bus ();
	tpm_pixel_if #(.DIM_W(DIM)) pixel_bus ();
	tpm_cfg_if   #(.DATA_W(DIM)) cfg_bus ();

	touch_point_to_pixel_mapper_core #(
		.FRAC_BITS(FRAC),
		.DIM_BITS (DIM)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.touch (touch_bus),
		.pixel (pixel_bus),
		.cfg   (cfg_bus)
	);

	always #10 clk = ~clk;

	// Bench copy of the register file. It only changes while the DUT is idle, so
	// the expectation for a touch item can be formed the moment it is accepted.
	int disp_w     = 1;
	int disp_h     = 1;
	int pad_left   = 0;
	int pad_top    = 0;
	int pad_right  = 0;
	int pad_bottom = 0;
	int turn_deg   = 0;

	// Pixel items still owed by the DUT, oldest first.
	pixel_item_t pending[$];

	// Idling switches for the two sides, changed from phase to phase.
	bit send_idle = 1'b1;
	bit take_idle = 1'b1;

	int n_fail    = 0;
	int n_sent    = 0;
	int n_checked = 0;
	int n_writes  = 0;
	int n_setting = 0;
	int st_count[4];

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Negative touches pin to zero and anything past one point zero pins to one.
	function automatic longint limit_to_unit(logic signed [IN_W-1:0] raw);
		longint v;
		v = longint'(raw);
		if (v < 0)
			v = 0;
		if (v > UNIT)
			v = UNIT;
		return v;
	endfunction

	// Scale a unit fraction onto one axis of the usable area. The product is
	// truncated, then offset by the near inset. A full-scale touch lands one
	// past the far edge and is pulled back onto the last usable pixel.
	function automatic logic [DIM-1:0] scale_axis(longint frac, int near, int span,
			int last);
		longint p;
		p = longint'(near) + ((frac * longint'(span)) >>> FRAC);
		if (p > last)
			p = longint'(last);
		if (p < near)
			p = longint'(near);
		return DIM'(p);
	endfunction

	// Expected pixel item for one touch under the current register values.
	// Errors are ranked: size first, then insets, then the rotation angle.
	function automatic pixel_item_t map_touch(logic signed [IN_W-1:0] tx,
			logic signed [IN_W-1:0] ty);
		pixel_item_t res;
		longint nx;
		longint ny;
		longint hx;
		longint hy;
		res.px = '0;
		res.py = '0;
		res.st = ST_OK;
		nx = limit_to_unit(tx);
		ny = limit_to_unit(ty);
		hx = 0;
		hy = 0;
		if (disp_w == 0 || disp_h == 0) begin
			res.st = ST_BAD_SIZE;
		end else if (pad_left + pad_right >= disp_w || pad_top + pad_bottom >= disp_h) begin
			// The sums are taken at full integer width, so two large insets
			// cannot wrap around and slip past this test.
			res.st = ST_BAD_INSET;
		end else begin
			case (turn_deg)
				ROT_0: begin
					hx = nx;
					hy = ny;
				end
				ROT_90: begin
					hx = UNIT - ny;
					hy = nx;
				end
				ROT_180: begin
					hx = UNIT - nx;
					hy = UNIT - ny;
				end
				ROT_270: begin
					hx = ny;
					hy = UNIT - nx;
				end
				default: res.st = ST_BAD_ROT;
			endcase
			if (res.st == ST_OK) begin
				res.px = scale_axis(hx, pad_left, disp_w - pad_left - pad_right,
					disp_w - pad_right - 1);
				res.py = scale_axis(hy, pad_top, disp_h - pad_top - pad_bottom,
					disp_h - pad_bottom - 1);
			end
		end
		return res;
	endfunction

	function automatic void note_failure(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------------

	// Send one touch item. Valid stays high after the handshake so that a
	// back-to-back item keeps it high without a glitch; the next call or a
	// drain lowers it. Every call starts and ends on a rising edge.
	task automatic send_touch(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y);
		int gap;
		pixel_item_t want;
		gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			touch_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		touch_bus.valid   <= 1'b1;
		touch_bus.touch_x <= x;
		touch_bus.touch_y <= y;
		do @(posedge clk); while (!touch_bus.ready);
		want = map_touch(x, y);
		pending.push_back(want);
		st_count[int'(want.st)]++;
		n_sent++;
	endtask

	// Stop sending and wait until every owed pixel item has come back.
	task automatic hold_until_drained();
		touch_bus.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	// Bring the DUT to rest before a register write: nothing owed, and a wait
	// longer than the pipe depth so that the pipe is empty.
	task automatic settle();
		hold_until_drained();
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// One register write. Valid is left high for a following write; callers
	// lower it once their sequence of writes is done.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		n_writes++;
		case (idx)
			REG_DRAWABLE_WIDTH:  disp_w     = int'(value);
			REG_DRAWABLE_HEIGHT: disp_h     = int'(value);
			REG_INSET_LEFT:      pad_left   = int'(value);
			REG_INSET_TOP:       pad_top    = int'(value);
			REG_INSET_RIGHT:     pad_right  = int'(value);
			REG_INSET_BOTTOM:    pad_bottom = int'(value);
			// Only the low nine bits of the data word reach the rotation register.
			REG_ROTATION_DEG:    turn_deg   = int'(value[ROT_BITS-1:0]);
			default: ;
		endcase
	endtask

	// Load a whole register set once the DUT is idle.
	task automatic apply_setting(int w, int h, int l, int t, int r, int b,
			logic [DIM-1:0] rot_word);
		settle();
		write_reg(REG_DRAWABLE_WIDTH, DIM'(w));
		write_reg(REG_DRAWABLE_HEIGHT, DIM'(h));
		write_reg(REG_INSET_LEFT, DIM'(l));
		write_reg(REG_INSET_TOP, DIM'(t));
		write_reg(REG_INSET_RIGHT, DIM'(r));
		write_reg(REG_INSET_BOTTOM, DIM'(b));
		write_reg(REG_ROTATION_DEG, rot_word);
		cfg_bus.valid <= 1'b0;
		n_setting++;
	endtask

	// ------------------------------------------------------------------------
	// Random stimulus helpers
	// ------------------------------------------------------------------------

	// Touch values lean toward the unit range, with the boundaries and the
	// full signed field mixed in so that every input bit toggles.
	function automatic logic signed [IN_W-1:0] pick_touch();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return '0;
					1: return IN_W'(UNIT);
					2: return IN_W'(UNIT - 1);
					3: return IN_W'(UNIT + 1);
					4: return IN_W'(-1);
					default: return IN_W'(TOUCH_MIN);
				endcase
			end
			1, 2, 3: return IN_W'($urandom);
			default: return IN_W'($urandom_range(0, int'(UNIT)));
		endcase
	endfunction

	// Drawable sizes: tiny surfaces, the largest one, and everything between.
	function automatic int pick_size();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 16);
			1: return DIM_MAX;
			2: return $urandom_range(1, 2048);
			default: return $urandom_range(1, DIM_MAX);
		endcase
	endfunction

	function automatic logic [ROT_BITS-1:0] pick_rotation();
		case ($urandom_range(0, 3))
			0: return ROT_0;
			1: return ROT_90;
			2: return ROT_180;
			default: return ROT_270;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// The receiver draws a stall for every item, then holds ready until the
	// item arrives.
	initial begin
		int stall;
		pixel_bus.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = take_idle ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				pixel_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pixel_bus.ready <= 1'b1;
			do @(posedge clk); while (!pixel_bus.valid);
		end
	end

	// Every accepted pixel item is matched against the oldest expectation.
	always @(posedge clk) begin
		pixel_item_t want;
		if (pixel_bus.valid && pixel_bus.ready) begin
			if (pending.size() == 0) begin
				note_failure($sformatf("pixel item with nothing owed: x=%0d y=%0d status=%0d",
					pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.status));
			end else begin
				want = pending.pop_front();
				if (pixel_bus.pixel_x !== want.px || pixel_bus.pixel_y !== want.py ||
						pixel_bus.status !== want.st) begin
					note_failure($sformatf(
						"item %0d: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
						n_checked, want.px, want.py, want.st, pixel_bus.pixel_x,
						pixel_bus.pixel_y, pixel_bus.status));
				end
				n_checked++;
			end
		end
	end

	// The watchdog ends a hung run: any handshake on any channel restarts it.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((touch_bus.valid && touch_bus.ready) || (pixel_bus.valid && pixel_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
		$display("touch_point_to_pixel_mapper_core: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Straight out of reset the surface is one pixel with no insets and no
	// rotation, so every touch, however wild, must land on pixel (0, 0).
	task automatic test_reset_values();
		send_touch('0, '0);
		send_touch(IN_W'(UNIT), IN_W'(UNIT));
		send_touch(IN_W'(TOUCH_MIN), IN_W'(TOUCH_MAX));
	endtask

	// Each error status, one item per setting. The rotation is also illegal in the
	// maximal-inset case and the last case, so the ranking of errors is exercised.
	task automatic test_error_status();
		// A zero width or a zero height reports a size error.
		apply_setting(0, 480, 0, 0, 0, 0, DIM'(ROT_0));
		send_touch(IN_W'(UNIT / 2), IN_W'(UNIT / 2));
		apply_setting(640, 0, 0, 0, 0, 0, DIM'(ROT_90));
		send_touch(IN_W'(UNIT / 2), IN_W'(UNIT / 2));
		// Both horizontal insets at their maximum: the sum exceeds the field
		// width and must still be seen as eating the whole drawable.
		apply_setting(DIM_MAX, 480, DIM_MAX, 0, DIM_MAX, 0, DIM'(9'd359));
		send_touch(IN_W'(UNIT / 4), IN_W'(UNIT / 4));
		// Vertical insets that exactly fill the height.
		apply_setting(640, 100, 0, 50, 0, 50, DIM'(ROT_180));
		send_touch(IN_W'(UNIT / 4), IN_W'(UNIT / 4));
		// A sound surface with an angle that is not a quarter turn.
		apply_setting(640, 480, 10, 10, 10, 10, DIM'(9'd359));
		send_touch(IN_W'(UNIT / 4), IN_W'(UNIT / 4));
	endtask

	// One setting per quarter turn, covering the full-scale touch, the most
	// negative and most positive inputs, and the largest and smallest usable
	// areas.
	task automatic test_rotations();
		apply_setting(DIM_MAX, DIM_MAX, 0, 0, 0, 0, DIM'(ROT_0));
		send_touch(IN_W'(UNIT), IN_W'(UNIT));
		send_touch(IN_W'(TOUCH_MIN), IN_W'(TOUCH_MAX));
		send_touch(IN_W'(UNIT - 1), IN_W'(1));

		// Upper data bits are set here; the rotation register must drop them.
		apply_setting(1920, 1080, 40, 20, 60, 30, {5'h1F, ROT_90});
		send_touch(IN_W'(UNIT), '0);
		send_touch(IN_W'(TOUCH_MAX), IN_W'(TOUCH_MIN));
		send_touch(IN_W'(UNIT / 3), IN_W'(UNIT - 1));

		// A single usable column at the far right edge and a single usable row at the top.
		apply_setting(DIM_MAX, 100, DIM_MAX - 1, 0, 0, 99, DIM'(ROT_180));
		send_touch('0, '0);
		send_touch(IN_W'(UNIT), IN_W'(UNIT + 1));
		send_touch(IN_W'(-1), IN_W'(UNIT / 2));

		apply_setting(2, DIM_MAX, 0, 8000, 1, 8382, DIM'(ROT_270));
		send_touch(IN_W'(UNIT), '0);
		send_touch('0, IN_W'(UNIT));
		send_touch(IN_W'(UNIT - 1), IN_W'(TOUCH_MIN));
	endtask

	// A write to an index past the register map leaves every register alone.
	task automatic test_ignored_write();
		apply_setting(800, 600, 5, 7, 11, 13, DIM'(ROT_90));
		settle();
		write_reg(REG_UNUSED, DIM'($urandom));
		cfg_bus.valid <= 1'b0;
		send_touch(IN_W'(UNIT / 2), IN_W'(UNIT / 5));
		send_touch(IN_W'(UNIT), IN_W'(UNIT));
	endtask

	// Random settings, each followed by a run of random touches. Most settings
	// are sound so that the arithmetic path sees the bulk of the traffic; the
	// rest are broken on purpose and get a shorter run. The phases rotate
	// through all four combinations of sender and receiver idling.
	task automatic test_random_mapping();
		int w;
		int h;
		int l;
		int t;
		int r;
		int b;
		int kind;
		int n_items;
		logic [ROT_BITS-1:0] rot9;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			w = pick_size();
			h = pick_size();
			l = $urandom_range(0, w - 1);
			r = $urandom_range(0, w - 1 - l);
			t = $urandom_range(0, h - 1);
			b = $urandom_range(0, h - 1 - t);
			if ($urandom_range(0, 3) == 0) begin
				l = 0;
				r = 0;
			end
			rot9 = pick_rotation();
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					if ($urandom_range(0, 1))
						w = 0;
					else
						h = 0;
				end
				1: begin
					// Insets that reach or pass the drawable edge on one axis.
					if ($urandom_range(0, 1)) begin
						l = $urandom_range(0, DIM_MAX);
						r = (w > l) ? $urandom_range(w - l, DIM_MAX) : $urandom_range(0, DIM_MAX);
					end else begin
						t = $urandom_range(0, DIM_MAX);
						b = (h > t) ? $urandom_range(h - t, DIM_MAX) : $urandom_range(0, DIM_MAX);
					end
				end
				2: begin
					do
						rot9 = ROT_BITS'($urandom_range(0, (1 << ROT_BITS) - 1));
					while (rot9 == ROT_0 || rot9 == ROT_90 || rot9 == ROT_180 || rot9 == ROT_270);
				end
				default: ;
			endcase
			n_items = (kind <= 2) ? 15 : 55;

			apply_setting(w, h, l, t, r, b, {(DIM - ROT_BITS)'($urandom), rot9});
			send_idle = (ph % 4 == 0) || (ph % 4 == 2);
			take_idle = (ph % 4 == 0) || (ph % 4 == 3);

			for (int i = 0; i < n_items; i++) begin
				// Once in the run the sender stops halfway through a phase and
				// lets the pipe run completely dry before it carries on.
				if (ph == 2 && i == n_items / 2)
					hold_until_drained();
				send_touch(pick_touch(), pick_touch());
			end
		end
		send_idle = 1'b1;
		take_idle = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		touch_bus.valid   <= 1'b0;
		touch_bus.touch_x <= '0;
		touch_bus.touch_y <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.index     <= '0;
		cfg_bus.data      <= '0;
		foreach (st_count[k])
			st_count[k] = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_error_status();
		test_rotations();
		test_ignored_write();
		test_random_mapping();

		// All items are in. Wait for the owed results, let the pipe run empty so that
		// any stray item shows, then judge the run.
		settle();
		if (pending.size() != 0)
			note_failure($sformatf("%0d pixel items never arrived", pending.size()));

		$display("Covered %0d touch items under %0d register settings (%0d register writes).",
			n_sent, n_setting, n_writes);
		$display("Status mix: %0d ok, %0d bad size, %0d bad inset, %0d bad rotation; %0d failures.",
			st_count[ST_OK], st_count[ST_BAD_SIZE], st_count[ST_BAD_INSET], st_count[ST_BAD_ROT],
			n_fail);
		if (n_fail == 0)
			$display("touch_point_to_pixel_mapper_core: match");
		else
			$display("touch_point_to_pixel_mapper_core: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
